/* hdl/gem_pkg.sv */
`default_nettype none

package gem_pkg;

    localparam int PIX_W       = 8;
    localparam int POS_W       = 10;
    localparam int ENERGY_W    = 10;
    localparam int TDATA_W     = 32;
    localparam int CFG_DATA_W  = 11;
    localparam int CFG_INDEX_W = 8;
    localparam int SIZE_RESET  = 1024;
    localparam int LINE_SLOTS  = 3;
    localparam int SLOT_W      = 2;
    localparam int NUM_EMIT    = 4;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = CFG_INDEX_W'(1);

    // bits of the per-pixel result mask, in delivery order
    localparam int EMIT_UP_LEFT   = 0;  // (r-1, c-1)
    localparam int EMIT_UP_CUR    = 1;  // (r-1, c) on the last column
    localparam int EMIT_LAST_LEFT = 2;  // (r, c-1) on the last row
    localparam int EMIT_LAST_CUR  = 3;  // (r, c) on the last pixel

    typedef logic [NUM_EMIT-1:0] emit_mask_t;

    // one column of the 3x3 window: rows r-2, r-1, r
    typedef struct packed {
        logic [PIX_W-1:0] above;
        logic [PIX_W-1:0] center;
        logic [PIX_W-1:0] below;
    } pix_col_t;

    // position of the pixel that completes a job, plus edge flags
    typedef struct packed {
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             first_row;  // r == 1, row above clamps
        logic             first_col;  // c == 1, left neighbor clamps
    } job_t;

endpackage

`default_nettype wire

/* hdl/gem_line_store.sv */
`default_nettype none

module gem_line_store #(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic                       aclk,
    input  wire logic                       access_en,
    input  wire logic [gem_pkg::SLOT_W-1:0] wr_slot,
    input  wire logic [gem_pkg::SLOT_W-1:0] above_slot,
    input  wire logic [gem_pkg::SLOT_W-1:0] center_slot,
    input  wire logic [$clog2(MAX_WIDTH)-1:0] col,
    input  wire logic [gem_pkg::PIX_W-1:0]  wr_data,
    output logic      [gem_pkg::PIX_W-1:0]  rd_above,
    output logic      [gem_pkg::PIX_W-1:0]  rd_center
);
    import gem_pkg::*;

    localparam int DEPTH = LINE_SLOTS * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);

    logic [PIX_W-1:0] mem [DEPTH];
    logic [AW-1:0]    wr_addr;
    logic [AW-1:0]    above_addr;
    logic [AW-1:0]    center_addr;

    // three rows side by side, one row per slot
    assign wr_addr     = AW'(int'(wr_slot) * MAX_WIDTH + int'(col));
    assign above_addr  = AW'(int'(above_slot) * MAX_WIDTH + int'(col));
    assign center_addr = AW'(int'(center_slot) * MAX_WIDTH + int'(col));

    always_ff @(posedge aclk) begin
        if (access_en) begin
            mem[wr_addr] <= wr_data;
            rd_above     <= mem[above_addr];
            rd_center    <= mem[center_addr];
        end
    end

endmodule

`default_nettype wire

/* hdl/gem_emit.sv */
`default_nettype none

module gem_emit (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         job_valid,
    output logic                              job_ready,
    input  wire gem_pkg::job_t                job,
    input  wire gem_pkg::emit_mask_t          job_mask,
    input  wire gem_pkg::pix_col_t            job_col,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    // [9:0] row, [19:10] column, [29:20] energy_x2, [31:30] zero
    output logic [gem_pkg::TDATA_W-1:0]       m_tdata,
    // frame_end
    output logic                              m_tlast
);
    import gem_pkg::*;

    pix_col_t   win0_reg, win1_reg, win2_reg;
    job_t       job_reg;
    emit_mask_t mask_reg;
    logic                m_tvalid_reg;
    logic [TDATA_W-1:0]  m_tdata_reg;
    logic                m_tlast_reg;

    emit_mask_t sel;
    emit_mask_t rest;
    logic       out_load;
    logic       issue;
    logic       job_take;
    logic       use_cur_col;
    logic       use_last_row;
    pix_col_t   vcol;
    pix_col_t   left_col;
    logic [PIX_W-1:0] h_left, h_right, v_above, v_below;
    logic [PIX_W-1:0] dx, dy;
    logic       x_dbl, y_dbl;
    logic [PIX_W:0]   ex, ey;
    logic [ENERGY_W-1:0] energy;
    logic [POS_W-1:0] res_row, res_col;

    assign out_load  = !m_tvalid_reg || m_tready;
    assign sel       = mask_reg & (~mask_reg + emit_mask_t'(1));
    assign rest      = mask_reg & ~sel;
    assign issue     = (|mask_reg) && out_load;
    assign job_ready = !(|mask_reg) || (issue && !(|rest));
    assign job_take  = job_valid && job_ready;

    always_comb begin
        use_cur_col  = sel[EMIT_UP_CUR] | sel[EMIT_LAST_CUR];
        use_last_row = sel[EMIT_LAST_LEFT] | sel[EMIT_LAST_CUR];
        vcol         = use_cur_col ? win2_reg : win1_reg;
        left_col     = (use_cur_col || job_reg.first_col) ? win1_reg : win0_reg;
        x_dbl        = use_cur_col || job_reg.first_col;
        if (use_last_row) begin
            // bottom edge: the pixel itself stands in for the row below
            h_left  = left_col.below;
            h_right = win2_reg.below;
            v_above = vcol.center;
            v_below = vcol.below;
            y_dbl   = 1'b1;
        end else begin
            h_left  = left_col.center;
            h_right = win2_reg.center;
            v_above = job_reg.first_row ? vcol.center : vcol.above;
            v_below = vcol.below;
            y_dbl   = job_reg.first_row;
        end
        dx      = (h_left > h_right) ? h_left - h_right : h_right - h_left;
        dy      = (v_above > v_below) ? v_above - v_below : v_below - v_above;
        ex      = x_dbl ? {dx, 1'b0} : {1'b0, dx};
        ey      = y_dbl ? {dy, 1'b0} : {1'b0, dy};
        energy  = ENERGY_W'(ex) + ENERGY_W'(ey);
        res_row = use_last_row ? job_reg.row : job_reg.row - POS_W'(1);
        res_col = use_cur_col ? job_reg.col : job_reg.col - POS_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (job_take) begin
                mask_reg <= job_mask;
            end else if (issue) begin
                mask_reg <= rest;
            end
            if (issue) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (job_take) begin
            win0_reg <= win1_reg;
            win1_reg <= win2_reg;
            win2_reg <= job_col;
            job_reg  <= job;
        end
        if (issue) begin
            m_tdata_reg <= TDATA_W'({energy, res_col, res_row});
            m_tlast_reg <= sel[EMIT_LAST_CUR];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    a_pending_fills_output: assert property (@(posedge aclk) disable iff (!aresetn)
        (|mask_reg) && out_load |=> m_tvalid_reg)
        else $error("pending result not moved to output register");

    a_stall_keeps_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (|mask_reg) && !out_load |=> $stable(mask_reg))
        else $error("pending results changed while output stalled");

    a_final_pixel_all_four: assert property (@(posedge aclk) disable iff (!aresetn)
        job_take && job_mask[EMIT_LAST_CUR] |->
            job_mask[EMIT_LAST_LEFT] && job_mask[EMIT_UP_CUR] && job_mask[EMIT_UP_LEFT])
        else $error("final pixel does not flush four results");

endmodule

`default_nettype wire

/* hdl/gradient_energy_map.sv */
// Gradient energy of a grey image streamed in raster order.
// Pixels enter on the s_ channel, one 8-bit grey level per transfer. Each
// result on the m_ channel carries row, column and twice the central
// difference energy (one fraction bit); tlast marks the last pixel of a frame.
// The cfg channel writes image_width (index 0) and image_height (index 1);
// values are clamped to 2..MAX_WIDTH and 2..MAX_HEIGHT. A write restarts the
// frame at pixel (0,0) and is meant for when the block is idle.
// Results lag the input by one row and one pixel: the pixel at (r,c) completes
// (r-1,c-1), plus (r-1,c) on the last column; on the last row it also flushes
// (r,c-1), plus (r,c) on the last pixel. A result passes stage one, the window
// stage and the output register before it shows on m_tvalid.
// Throughput is one pixel per cycle while m_tready is high; a pixel with k results
// holds the input until all k leave, as the output register takes one result per cycle.
// Row ends past row 0 and last-row pixels past column 0 give two; the final pixel four.
// Rows live in a three-row line store with one write and two reads per pixel.
// While m_tready is low, results wait in the output register, the window stage
// and stage one, and s_tready falls once those are full.
// Reset returns to pixel (0,0) with 1024x1024 (clamped) size and empties the
// pipeline; the line store keeps its contents and needs no clearing.
`default_nettype none

module gradient_energy_map #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // [7:0] pixel
    input  wire logic [gem_pkg::PIX_W-1:0]         s_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // [9:0] row, [19:10] column, [29:20] energy_x2, [31:30] zero
    output logic [gem_pkg::TDATA_W-1:0]            m_tdata,
    // frame_end
    output logic                                   m_tlast,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [gem_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [gem_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import gem_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int RST_LAST_COL = ((MAX_WIDTH < SIZE_RESET) ? MAX_WIDTH : SIZE_RESET) - 1;
    localparam int RST_LAST_ROW = ((MAX_HEIGHT < SIZE_RESET) ? MAX_HEIGHT : SIZE_RESET) - 1;

    logic [CW-1:0]     col_reg, col_next;
    logic [RW-1:0]     row_reg, row_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [CW-1:0]     last_col_reg;
    logic [RW-1:0]     last_row_reg;
    logic              s1_valid_reg;
    job_t              s1_job_reg, s1_job_next;
    emit_mask_t        s1_mask_reg, s1_mask_next;
    logic [PIX_W-1:0]  s1_pix_reg;

    logic              s_accept;
    logic              cfg_wr_width, cfg_wr_height, cfg_wr;
    logic [CW-1:0]     cfg_last_col;
    logic [RW-1:0]     cfg_last_row;
    logic [SLOT_W-1:0] above_slot, center_slot;
    logic [PIX_W-1:0]  rd_above, rd_center;
    logic              job_ready;
    pix_col_t          job_col;
    logic              at_last_col, at_last_row, past_first_col, past_first_row;

    assign cfg_ready     = 1'b1;
    assign cfg_wr_width  = cfg_valid && cfg_ready && (cfg_index == REG_IMAGE_WIDTH);
    assign cfg_wr_height = cfg_valid && cfg_ready && (cfg_index == REG_IMAGE_HEIGHT);
    assign cfg_wr        = cfg_wr_width || cfg_wr_height;

    assign s_tready = !s1_valid_reg || job_ready;
    assign s_accept = s_tvalid && s_tready;

    // size register holds the last index of the clamped size
    always_comb begin
        cfg_last_col = CW'(MAX_WIDTH - 1);
        if (cfg_data < CFG_DATA_W'(2)) begin
            cfg_last_col = CW'(1);
        end else if (int'(cfg_data) <= MAX_WIDTH) begin
            cfg_last_col = CW'(cfg_data - CFG_DATA_W'(1));
        end
        cfg_last_row = RW'(MAX_HEIGHT - 1);
        if (cfg_data < CFG_DATA_W'(2)) begin
            cfg_last_row = RW'(1);
        end else if (int'(cfg_data) <= MAX_HEIGHT) begin
            cfg_last_row = RW'(cfg_data - CFG_DATA_W'(1));
        end
    end

    always_comb begin
        at_last_col    = (col_reg == last_col_reg);
        at_last_row    = (row_reg == last_row_reg);
        past_first_col = (col_reg != '0);
        past_first_row = (row_reg != '0);

        // slots of rows r-1 and r-2 in the rotation
        center_slot = (slot_reg == '0) ? SLOT_W'(LINE_SLOTS - 1) : slot_reg - SLOT_W'(1);
        above_slot  = (center_slot == '0) ? SLOT_W'(LINE_SLOTS - 1)
                                          : center_slot - SLOT_W'(1);

        col_next  = col_reg + CW'(1);
        row_next  = row_reg;
        slot_next = slot_reg;
        if (at_last_col) begin
            col_next = '0;
            if (at_last_row) begin
                row_next  = '0;
                slot_next = '0;
            end else begin
                row_next  = row_reg + RW'(1);
                slot_next = (slot_reg == SLOT_W'(LINE_SLOTS - 1)) ? '0 : slot_reg + SLOT_W'(1);
            end
        end

        s1_mask_next = '0;
        s1_mask_next[EMIT_UP_LEFT]   = past_first_row && past_first_col;
        s1_mask_next[EMIT_UP_CUR]    = past_first_row && at_last_col;
        s1_mask_next[EMIT_LAST_LEFT] = at_last_row && past_first_col;
        s1_mask_next[EMIT_LAST_CUR]  = at_last_row && at_last_col;

        s1_job_next.row       = POS_W'(row_reg);
        s1_job_next.col       = POS_W'(col_reg);
        s1_job_next.first_row = (row_reg == RW'(1));
        s1_job_next.first_col = (col_reg == CW'(1));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            slot_reg     <= '0;
            last_col_reg <= CW'(RST_LAST_COL);
            last_row_reg <= RW'(RST_LAST_ROW);
            s1_valid_reg <= 1'b0;
            s1_mask_reg  <= '0;
        end else begin
            if (cfg_wr) begin
                col_reg  <= '0;
                row_reg  <= '0;
                slot_reg <= '0;
                if (cfg_wr_width) begin
                    last_col_reg <= cfg_last_col;
                end
                if (cfg_wr_height) begin
                    last_row_reg <= cfg_last_row;
                end
            end else if (s_accept) begin
                col_reg  <= col_next;
                row_reg  <= row_next;
                slot_reg <= slot_next;
            end
            if (s_accept) begin
                s1_valid_reg <= 1'b1;
                s1_mask_reg  <= s1_mask_next;
            end else if (job_ready) begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_job_reg <= s1_job_next;
            s1_pix_reg <= s_tdata;
        end
    end

    gem_line_store #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_store (
        .aclk        (aclk),
        .access_en   (s_accept),
        .wr_slot     (slot_reg),
        .above_slot  (above_slot),
        .center_slot (center_slot),
        .col         (col_reg),
        .wr_data     (s_tdata),
        .rd_above    (rd_above),
        .rd_center   (rd_center)
    );

    assign job_col = '{above: rd_above, center: rd_center, below: s1_pix_reg};

    gem_emit u_emit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (s1_valid_reg),
        .job_ready (job_ready),
        .job       (s1_job_reg),
        .job_mask  (s1_valid_reg ? s1_mask_reg : emit_mask_t'(0)),
        .job_col   (job_col),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    a_s1_holds_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && !job_ready |=> s1_valid_reg && $stable(s1_mask_reg))
        else $error("stage one lost its job while stalled");

    a_frame_wraps: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && !cfg_wr && at_last_col && at_last_row |=>
            row_reg == '0 && col_reg == '0 && slot_reg == '0)
        else $error("position did not wrap at end of frame");

    a_position_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        col_reg <= last_col_reg && row_reg <= last_row_reg)
        else $error("pixel position outside the image");

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import gem_pkg::*;

    localparam int MAX_DIM       = 1024;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int SETTLE_CYCLES = 16;
    localparam int MAX_REPORTS   = 10;

    typedef enum logic {STEP_CFG, STEP_PIX} step_kind_t;
    typedef enum logic [1:0] {IDLE_NONE, IDLE_SRC, IDLE_SINK, IDLE_BOTH} idle_mode_t;
    typedef enum logic [1:0] {PIX_RANDOM, PIX_TWO_LEVEL, PIX_SMOOTH} pix_style_t;

    typedef struct packed {
        step_kind_t             kind;
        logic [CFG_INDEX_W-1:0] index;
        logic [CFG_DATA_W-1:0]  value;   // register value or pixel
        logic signed [11:0]     energy;  // energy of every result this pixel completes
    } dir_step_t;

    typedef struct packed {
        logic [POS_W-1:0]    row;
        logic [POS_W-1:0]    col;
        logic [ENERGY_W-1:0] energy;
        logic                frame_end;
    } energy_rec_t;

    localparam logic signed [11:0] NO_FIXED = -12'sd1;
    localparam int NUM_DIR = 29;

    // reset size first row, then full-swing and flat 2x2 frames, clamped sizes, 3x3
    localparam dir_step_t DIR_STEPS [NUM_DIR] = '{
        '{STEP_PIX, 8'd0, 11'd17, NO_FIXED},
        '{STEP_PIX, 8'd0, 11'd200, NO_FIXED},
        '{STEP_CFG, REG_IMAGE_WIDTH, 11'd2, NO_FIXED},
        '{STEP_CFG, REG_IMAGE_HEIGHT, 11'd2, NO_FIXED},
        '{STEP_PIX, 8'd0, 11'd0, NO_FIXED},
        '{STEP_PIX, 8'd0, 11'd255, NO_FIXED},
        '{STEP_PIX, 8'd0, 11'd255, NO_FIXED},
        '{STEP_PIX, 8'd0, 11'd0, 12'sd1020},
        '{STEP_PIX, 8'd0, 11'd7, NO_FIXED},
        '{STEP_PIX, 8'd0, 11'd7, NO_FIXED},
        '{STEP_PIX, 8'd0, 11'd7, NO_FIXED},
        '{STEP_PIX, 8'd0, 11'd7, 12'sd0},
        '{STEP_CFG, REG_IMAGE_WIDTH, 11'd0, NO_FIXED},
        '{STEP_CFG, REG_IMAGE_HEIGHT, 11'd1, NO_FIXED},
        '{STEP_PIX, 8'd0, 11'd255, NO_FIXED},
        '{STEP_PIX, 8'd0, 11'd0, NO_FIXED},
        '{STEP_PIX, 8'd0, 11'd0, NO_FIXED},
        '{STEP_PIX, 8'd0, 11'd255, 12'sd1020},
        '{STEP_CFG, REG_IMAGE_WIDTH, 11'd3, NO_FIXED},
        '{STEP_CFG, REG_IMAGE_HEIGHT, 11'd3, NO_FIXED},
        '{STEP_PIX, 8'd0, 11'd10, NO_FIXED},
        '{STEP_PIX, 8'd0, 11'd200, NO_FIXED},
        '{STEP_PIX, 8'd0, 11'd30, NO_FIXED},
        '{STEP_PIX, 8'd0, 11'd255, NO_FIXED},
        '{STEP_PIX, 8'd0, 11'd0, NO_FIXED},
        '{STEP_PIX, 8'd0, 11'd128, NO_FIXED},
        '{STEP_PIX, 8'd0, 11'd60, NO_FIXED},
        '{STEP_PIX, 8'd0, 11'd90, NO_FIXED},
        '{STEP_PIX, 8'd0, 11'd250, NO_FIXED}
    };

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [PIX_W-1:0]       s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [TDATA_W-1:0]     m_tdata;
    logic                   m_tlast;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    // predictor state
    logic [PIX_W-1:0]      line_mem [3*MAX_DIM];
    int unsigned           pos_row = 0;
    int unsigned           pos_col = 0;
    logic [CFG_DATA_W-1:0] width_reg  = CFG_DATA_W'(SIZE_RESET);
    logic [CFG_DATA_W-1:0] height_reg = CFG_DATA_W'(SIZE_RESET);
    energy_rec_t           energy_q [$];
    int                    fixed_energy = -1;

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int cycle_count    = 0;
    int pix_count      = 0;
    int result_count   = 0;
    int cfg_count      = 0;
    int mismatch_count = 0;

    gradient_energy_map #(
        .MAX_WIDTH (MAX_DIM),
        .MAX_HEIGHT(MAX_DIM)
    ) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always #4 aclk = ~aclk;

    function automatic int unsigned used_size(input logic [CFG_DATA_W-1:0] v);
        if (v < 2) return 2;
        if (v > MAX_DIM) return MAX_DIM;
        return v;
    endfunction

    function automatic int unsigned slot(input int unsigned r, input int unsigned c);
        return (r % 3) * MAX_DIM + c;
    endfunction

    function automatic int unsigned gap(input int unsigned a, input int unsigned b);
        return (a > b) ? a - b : b - a;
    endfunction

    task automatic queue_energy(input int unsigned i, input int unsigned j,
                                input int unsigned w, input int unsigned h);
        int unsigned jl, jr, it, ib, ex, ey;
        energy_rec_t rec;
        jl = (j > 0) ? j - 1 : 0;
        jr = (j + 1 < w) ? j + 1 : w - 1;
        it = (i > 0) ? i - 1 : 0;
        ib = (i + 1 < h) ? i + 1 : h - 1;
        ex = gap(line_mem[slot(i, jr)], line_mem[slot(i, jl)]);
        ey = gap(line_mem[slot(ib, j)], line_mem[slot(it, j)]);
        // one-sided difference at the border weighs double
        if (jr - jl == 1) ex = 2 * ex;
        if (ib - it == 1) ey = 2 * ey;
        rec.row       = POS_W'(i);
        rec.col       = POS_W'(j);
        rec.energy    = (fixed_energy >= 0) ? ENERGY_W'(fixed_energy) : ENERGY_W'(ex + ey);
        rec.frame_end = (i == h - 1) && (j == w - 1);
        energy_q.push_back(rec);
    endtask

    task automatic predict_pixel(input logic [PIX_W-1:0] p);
        int unsigned w, h, r, c;
        w = used_size(width_reg);
        h = used_size(height_reg);
        r = pos_row;
        c = pos_col;
        if (r >= h || c >= w) begin
            r = 0;
            c = 0;
        end
        line_mem[slot(r, c)] = p;
        if (r >= 1) begin
            if (c >= 1) queue_energy(r - 1, c - 1, w, h);
            if (c == w - 1) queue_energy(r - 1, c, w, h);
        end
        // last row flushes itself
        if (r == h - 1) begin
            if (c >= 1) queue_energy(r, c - 1, w, h);
            if (c == w - 1) queue_energy(r, c, w, h);
        end
        c++;
        if (c >= w) begin
            c = 0;
            r++;
            if (r >= h) r = 0;
        end
        pos_row = r;
        pos_col = c;
        pix_count++;
    endtask

    task automatic push_pixel(input logic [PIX_W-1:0] p);
        @(negedge aclk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= p;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_pixel(p);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            REG_IMAGE_WIDTH:  width_reg  = val;
            REG_IMAGE_HEIGHT: height_reg = val;
            default: ;
        endcase
        // any write restarts the frame
        pos_row = 0;
        pos_col = 0;
        cfg_count++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (energy_q.size() != 0) @(posedge aclk);
        // first-row pixels leave nothing in the queue but may still be in flight
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_idling(input idle_mode_t mode);
        case (mode)
            IDLE_NONE: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
            IDLE_SRC:  begin src_idle_pct = 63; sink_stall_pct = 0;  end
            IDLE_SINK: begin src_idle_pct = 0;  sink_stall_pct = 63; end
            default:   begin src_idle_pct = 30; sink_stall_pct = 30; end
        endcase
    endtask

    function automatic logic [PIX_W-1:0] next_pixel(input pix_style_t style,
                                                     input logic [PIX_W-1:0] prev);
        int v;
        case (style)
            PIX_TWO_LEVEL: return ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
            PIX_SMOOTH: begin
                v = int'(prev) + int'($urandom_range(8)) - 4;
                if (v < 0) v = 0;
                if (v > 255) v = 255;
                return PIX_W'(v);
            end
            default: return PIX_W'($urandom);
        endcase
    endfunction

    task automatic run_phase(input int unsigned w_val, input int unsigned h_val,
                             input bit write_w, input bit write_h,
                             input int unsigned n_pix, input idle_mode_t mode,
                             input pix_style_t style);
        logic [PIX_W-1:0] p;
        wait_drained();
        if (write_w) write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(w_val));
        if (write_h) write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(h_val));
        set_idling(mode);
        p = PIX_W'($urandom);
        repeat (n_pix) begin
            p = next_pixel(style, p);
            push_pixel(p);
        end
    endtask

    task automatic flag_mismatch(input string what, input energy_rec_t want,
                                 input energy_rec_t got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $write("%0t %s: expected row %0d col %0d energy %0d last %0b,",
                   $time, what, want.row, want.col, want.energy, want.frame_end);
            $display(" got row %0d col %0d energy %0d last %0b",
                     got.row, got.col, got.energy, got.frame_end);
        end
    endtask

    always @(negedge aclk) m_tready <= ($urandom_range(99) >= sink_stall_pct);

    always @(posedge aclk) begin : watch_results
        energy_rec_t got;
        energy_rec_t want;
        if (aresetn && m_tvalid && m_tready) begin
            result_count++;
            got.row       = m_tdata[POS_W-1:0];
            got.col       = m_tdata[2*POS_W-1:POS_W];
            got.energy    = m_tdata[2*POS_W+ENERGY_W-1:2*POS_W];
            got.frame_end = m_tlast;
            if (energy_q.size() == 0) begin
                flag_mismatch("unexpected transfer", '0, got);
            end else begin
                want = energy_q.pop_front();
                if (got.row !== want.row || got.col !== want.col ||
                    got.energy !== want.energy || got.frame_end !== want.frame_end)
                    flag_mismatch("mismatch", want, got);
                else if (m_tdata[TDATA_W-1:2*POS_W+ENERGY_W] !== '0)
                    flag_mismatch("nonzero tdata padding", want, got);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles with %0d results outstanding",
                     cycle_count, energy_q.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin : stimulus
        int unsigned w, h;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (DIR_STEPS[k]) begin
            if (DIR_STEPS[k].kind == STEP_CFG) begin
                wait_drained();
                write_reg(DIR_STEPS[k].index, DIR_STEPS[k].value);
            end else begin
                fixed_energy = DIR_STEPS[k].energy;
                push_pixel(PIX_W'(DIR_STEPS[k].value));
                fixed_energy = -1;
            end
        end

        // small frames, partial frames and frame wraps under every idling mix
        for (int ph = 0; ph < 12; ph++) begin
            w = $urandom_range(2, 12);
            h = $urandom_range(2, 8);
            if ($urandom_range(5) == 0) w = $urandom_range(1);
            if ($urandom_range(5) == 0) h = $urandom_range(1);
            run_phase(w, h, (ph % 3) != 1, (ph % 3) != 2, $urandom_range(20, 40),
                      idle_mode_t'(ph % 4), pix_style_t'($urandom_range(2)));
        end

        // oversized width and height clamped to the largest image, then 2x1024 and 3x3 frames
        run_phase(2047, 2, 1'b1, 1'b1, 40, IDLE_BOTH, PIX_RANDOM);
        run_phase(0, 2047, 1'b1, 1'b1, 40, IDLE_NONE, PIX_RANDOM);
        run_phase(2, 1024, 1'b1, 1'b1, 30, IDLE_SRC, PIX_SMOOTH);
        run_phase(3, 3, 1'b1, 1'b1, 20, IDLE_SINK, PIX_TWO_LEVEL);

        wait_drained();
        $display("%0d pixels over %0d register writes, sizes from 2x2 up to 1024 wide and tall",
                 pix_count, cfg_count);
        $display("%0d energies checked, %0d mismatches", result_count, mismatch_count);
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
